// ===== hw/rtl/timed_multichannel_led_blinker_assert.svh =====
// assertion macros for the indicator blinker
`ifndef TIMED_MULTICHANNEL_LED_BLINKER_ASSERT_SVH
`define TIMED_MULTICHANNEL_LED_BLINKER_ASSERT_SVH

// implication checked on every rising clock edge, held off while in reset
`define TMLB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequence is checked in the cycle after the antecedent
`define TMLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tmlb_pkg.sv =====
`default_nettype none

package tmlb_pkg;

    // channel layout
    localparam int NUM_CHAN        = 8;
    localparam int GROUP_A_LAST    = 2;
    localparam int GROUP_B_LAST    = 5;
    localparam int WARN_FIRST_CHAN = 3;

    // counter width default
    localparam int COUNT_WIDTH_DEF = 16;

    // configuration port
    localparam int CFG_WIDTH      = 16;
    localparam int CFG_ADDR_WIDTH = 3;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_GROUP_A_DURATION = 3'd0,
        REG_GROUP_B_DURATION = 3'd1,
        REG_GROUP_C_DURATION = 3'd2,
        REG_BLINK_HALF       = 3'd3,
        REG_WARN_HALF        = 3'd4
    } cfg_reg_t;

    // register reset values
    localparam logic [CFG_WIDTH-1:0] GROUP_A_DURATION_RST = 16'd10000;
    localparam logic [CFG_WIDTH-1:0] GROUP_B_DURATION_RST = 16'd10000;
    localparam logic [CFG_WIDTH-1:0] GROUP_C_DURATION_RST = 16'd15000;
    localparam logic [CFG_WIDTH-1:0] BLINK_HALF_RST       = 16'd500;
    localparam logic [CFG_WIDTH-1:0] WARN_HALF_RST        = 16'd300;

    // item commands
    localparam int CMD_WIDTH = 2;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_TICK    = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_CLEAR   = 2'd2
    } cmd_t;

    // stream widths
    localparam int CHAN_WIDTH     = 3;
    localparam int S_TDATA_WIDTH  = 8;
    localparam int M_TDATA_WIDTH  = 24;
    localparam int M_FIELDS_WIDTH = 2 * NUM_CHAN + 2;

endpackage

`default_nettype wire

// ===== hw/rtl/timed_multichannel_led_blinker.sv =====
// A result item is shown in the cycle after its input item is accepted.
// Throughput: one item per cycle while s_tready is high; all eight channel
// counters, the warning light and the link light update side by side in the accept cycle.
// s_tready drops only while a result waits in the output register.
// Reset (aresetn low, synchronous): all channels and lights dark and inactive,
// counters zero, registers back to 10000, 10000, 15000, 500, 300 ms.
`default_nettype none

`include "timed_multichannel_led_blinker_assert.svh"

module timed_multichannel_led_blinker
    import tmlb_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    // configuration write port
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [CFG_WIDTH-1:0]      cfg_data,

    // input items
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [S_TDATA_WIDTH-1:0]  s_tdata,  // [2:0] channel, [3] link_up
    input  wire logic [CMD_WIDTH-1:0]      s_tuser,  // [1:0] command

    // result items
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [M_TDATA_WIDTH-1:0]       m_tdata   // [7:0] lamps, [15:8] active_mask,
                                                     // [16] warning_lamp, [17] link_lamp
);

    localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    // configuration registers
    logic [CFG_WIDTH-1:0] dur_a_reg, dur_b_reg, dur_c_reg;
    logic [CFG_WIDTH-1:0] blink_half_reg, warn_half_reg;

    // channel and light state
    logic [NUM_CHAN-1:0]    active_reg, active_next;
    logic [NUM_CHAN-1:0]    lit_reg, lit_next;
    logic [COUNT_WIDTH-1:0] since_start_reg  [NUM_CHAN];
    logic [COUNT_WIDTH-1:0] since_start_next [NUM_CHAN];
    logic [COUNT_WIDTH-1:0] since_toggle_reg  [NUM_CHAN];
    logic [COUNT_WIDTH-1:0] since_toggle_next [NUM_CHAN];
    logic                   warn_active_reg, warn_active_next;
    logic                   warn_lit_reg, warn_lit_next;
    logic [COUNT_WIDTH-1:0] warn_cnt_reg, warn_cnt_next;
    logic                   link_lit_reg, link_lit_next;

    // output register
    logic                     m_tvalid_reg;
    logic [M_TDATA_WIDTH-1:0] m_tdata_reg;

    logic                  s_accept;
    cmd_t                  cmd;
    logic [CHAN_WIDTH-1:0] chan_sel;
    logic                  link_up;

    // saturating increment at the all-ones value
    function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
        return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
    endfunction

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign chan_sel = s_tdata[CHAN_WIDTH-1:0];
    assign link_up  = s_tdata[CHAN_WIDTH];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_a_reg      <= GROUP_A_DURATION_RST;
            dur_b_reg      <= GROUP_B_DURATION_RST;
            dur_c_reg      <= GROUP_C_DURATION_RST;
            blink_half_reg <= BLINK_HALF_RST;
            warn_half_reg  <= WARN_HALF_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_GROUP_A_DURATION: dur_a_reg      <= cfg_data;
                REG_GROUP_B_DURATION: dur_b_reg      <= cfg_data;
                REG_GROUP_C_DURATION: dur_c_reg      <= cfg_data;
                REG_BLINK_HALF:       blink_half_reg <= cfg_data;
                REG_WARN_HALF:        warn_half_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state for one item
    always_comb begin
        logic [CFG_WIDTH-1:0]   dur;
        logic [COUNT_WIDTH-1:0] ss;
        logic [COUNT_WIDTH-1:0] st;
        logic                   any_alert;

        active_next      = active_reg;
        lit_next         = lit_reg;
        since_start_next = since_start_reg;
        since_toggle_next = since_toggle_reg;
        warn_active_next = warn_active_reg;
        warn_lit_next    = warn_lit_reg;
        warn_cnt_next    = warn_cnt_reg;
        link_lit_next    = link_lit_reg;
        dur              = dur_a_reg;
        ss               = '0;
        st               = '0;
        any_alert        = 1'b0;

        case (cmd)
            CMD_TICK: begin
                // channel counters, end of blink, toggles
                for (int i = 0; i < NUM_CHAN; i++) begin
                    if (i <= GROUP_A_LAST)      dur = dur_a_reg;
                    else if (i <= GROUP_B_LAST) dur = dur_b_reg;
                    else                        dur = dur_c_reg;
                    ss = count_up(since_start_reg[i]);
                    st = count_up(since_toggle_reg[i]);
                    if (active_reg[i]) begin
                        since_start_next[i]  = ss;
                        since_toggle_next[i] = st;
                        if (CMP_W'(ss) >= CMP_W'(dur)) begin
                            active_next[i] = 1'b0;
                            lit_next[i]    = 1'b0;
                        end else if (CMP_W'(st) >= CMP_W'(blink_half_reg)) begin
                            lit_next[i]          = !lit_reg[i];
                            since_toggle_next[i] = '0;
                        end
                    end
                end

                // warning light follows the later channels
                any_alert = |active_next[NUM_CHAN-1:WARN_FIRST_CHAN];
                if (!any_alert) begin
                    warn_active_next = 1'b0;
                    warn_lit_next    = 1'b0;
                end else begin
                    if (!warn_active_reg) begin
                        warn_active_next = 1'b1;
                        warn_lit_next    = 1'b1;
                        warn_cnt_next    = '0;
                    end else begin
                        warn_cnt_next = count_up(warn_cnt_reg);
                    end
                    if (CMP_W'(warn_cnt_next) >= CMP_W'(warn_half_reg)) begin
                        warn_lit_next = !warn_lit_next;
                        warn_cnt_next = '0;
                    end
                end

                link_lit_next = link_up;
            end
            CMD_TRIGGER: begin
                active_next[chan_sel]       = 1'b1;
                lit_next[chan_sel]          = 1'b1;
                since_start_next[chan_sel]  = '0;
                since_toggle_next[chan_sel] = '0;
            end
            CMD_CLEAR: begin
                active_next      = '0;
                lit_next         = '0;
                warn_active_next = 1'b0;
                warn_lit_next    = 1'b0;
            end
            default: ;
        endcase
    end

    // state update on an accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= '0;
            lit_reg         <= '0;
            warn_active_reg <= 1'b0;
            warn_lit_reg    <= 1'b0;
            warn_cnt_reg    <= '0;
            link_lit_reg    <= 1'b0;
            for (int i = 0; i < NUM_CHAN; i++) begin
                since_start_reg[i]  <= '0;
                since_toggle_reg[i] <= '0;
            end
        end else if (s_accept) begin
            active_reg       <= active_next;
            lit_reg          <= lit_next;
            warn_active_reg  <= warn_active_next;
            warn_lit_reg     <= warn_lit_next;
            warn_cnt_reg     <= warn_cnt_next;
            link_lit_reg     <= link_lit_next;
            since_start_reg  <= since_start_next;
            since_toggle_reg <= since_toggle_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {(M_TDATA_WIDTH - M_FIELDS_WIDTH)'(0),
                            link_lit_next, warn_lit_next, active_next, lit_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks on the block state
    `TMLB_ASSERT_IMPL(a_lit_needs_active, 1'b1, (lit_reg & ~active_reg) == '0,
        "channel lit while inactive")
    `TMLB_ASSERT_IMPL(a_warn_lit_needs_active, warn_lit_reg, warn_active_reg,
        "warning lit while inactive")
    `TMLB_ASSERT_IMPL(a_warn_follows_chans, warn_active_reg,
        |active_reg[NUM_CHAN-1:WARN_FIRST_CHAN], "warning active with no alert channel")
    `TMLB_ASSERT_NEXT(a_clear_darkens, s_accept && (s_tuser == CMD_CLEAR),
        (active_reg == '0) && !warn_active_reg && (m_tdata[16:0] == '0),
        "clear item left something lit")

endmodule

`default_nettype wire

// ===== sim/tb_timed_multichannel_led_blinker.sv =====
module tb_timed_multichannel_led_blinker;
    timeunit 1ns;
    timeprecision 1ps;

    import tmlb_pkg::*;

    localparam int NUM_REGS = 5;
    // command code with no function, and a register index that does not exist
    localparam logic [CMD_WIDTH-1:0]      CMD_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_UNUSED = 3'd7;
    localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_TOP = '1;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
    logic [CFG_WIDTH-1:0]      cfg_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [S_TDATA_WIDTH-1:0]  s_tdata;   // [2:0] channel, [3] link_up
    logic [CMD_WIDTH-1:0]      s_tuser;   // [1:0] command
    logic                      m_tvalid;
    logic                      m_tready;
    logic [M_TDATA_WIDTH-1:0]  m_tdata;   // [7:0] lamps, [15:8] active_mask,
                                          // [16] warning_lamp, [17] link_lamp

    typedef struct {
        logic [NUM_CHAN-1:0] lamps;
        logic [NUM_CHAN-1:0] active;
        logic                warn;
        logic                link;
    } lights_t;

    lights_t expected_lights[$];
    int      mismatches = 0;
    bit      steady = 1'b0;

    // mirror of the blinker state and its registers
    logic [NUM_CHAN-1:0]        chan_on;
    logic [NUM_CHAN-1:0]        chan_lit;
    logic [COUNT_WIDTH_DEF-1:0] since_start [NUM_CHAN];
    logic [COUNT_WIDTH_DEF-1:0] since_toggle [NUM_CHAN];
    logic                       warn_on;
    logic                       warn_lit;
    logic [COUNT_WIDTH_DEF-1:0] warn_count;
    logic                       link_lit;
    logic [CFG_WIDTH-1:0]       reg_val [NUM_REGS];

    timed_multichannel_led_blinker DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // saturating millisecond counter
    function automatic logic [COUNT_WIDTH_DEF-1:0] count_sat(
        input logic [COUNT_WIDTH_DEF-1:0] c);
        return (c == COUNT_TOP) ? c : c + 1'b1;
    endfunction

    function automatic logic [CFG_WIDTH-1:0] group_time(input int ch);
        if (ch <= GROUP_A_LAST) return reg_val[REG_GROUP_A_DURATION];
        if (ch <= GROUP_B_LAST) return reg_val[REG_GROUP_B_DURATION];
        return reg_val[REG_GROUP_C_DURATION];
    endfunction

    // apply one accepted item to the mirror and queue the lights it shows
    function automatic void step_lights(input logic [CMD_WIDTH-1:0] cmd,
                                        input logic [CHAN_WIDTH-1:0] ch,
                                        input logic link);
        lights_t shown;
        logic    alert;
        alert = 1'b0;
        case (cmd)
            CMD_TICK: begin
                for (int i = 0; i < NUM_CHAN; i++) begin
                    if (chan_on[i]) begin
                        since_start[i]  = count_sat(since_start[i]);
                        since_toggle[i] = count_sat(since_toggle[i]);
                        if (since_start[i] >= group_time(i)) begin
                            chan_on[i]  = 1'b0;
                            chan_lit[i] = 1'b0;
                        end else if (since_toggle[i] >= reg_val[REG_BLINK_HALF]) begin
                            chan_lit[i]     = ~chan_lit[i];
                            since_toggle[i] = '0;
                        end
                    end
                end
                for (int i = WARN_FIRST_CHAN; i < NUM_CHAN; i++) alert |= chan_on[i];
                if (!alert) begin
                    warn_on  = 1'b0;
                    warn_lit = 1'b0;
                end else begin
                    if (!warn_on) begin
                        warn_on    = 1'b1;
                        warn_lit   = 1'b1;
                        warn_count = '0;
                    end else begin
                        warn_count = count_sat(warn_count);
                    end
                    if (warn_count >= reg_val[REG_WARN_HALF]) begin
                        warn_lit   = ~warn_lit;
                        warn_count = '0;
                    end
                end
                link_lit = link;
            end
            CMD_TRIGGER: begin
                chan_on[ch]      = 1'b1;
                chan_lit[ch]     = 1'b1;
                since_start[ch]  = '0;
                since_toggle[ch] = '0;
            end
            CMD_CLEAR: begin
                chan_on  = '0;
                chan_lit = '0;
                warn_on  = 1'b0;
                warn_lit = 1'b0;
            end
            default: ;
        endcase
        shown.lamps  = chan_lit;
        shown.active = chan_on;
        shown.warn   = warn_lit;
        shown.link   = link_lit;
        expected_lights.push_back(shown);
    endfunction

    // offer one item after a random gap (none while steady) and wait until it is taken
    task automatic push_item(input logic [CMD_WIDTH-1:0] cmd,
                             input logic [CHAN_WIDTH-1:0] ch,
                             input logic link);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_WIDTH'({link, ch});
        do @(posedge aclk); while (!s_tready);
        step_lights(cmd, ch, link);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_lights.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // write all registers while idle, plus one write to an index that does not exist
    task automatic configure(input logic [CFG_WIDTH-1:0] dur_a, dur_b, dur_c,
                             input logic [CFG_WIDTH-1:0] blink_half, warn_half);
        logic [CFG_WIDTH-1:0] vals [NUM_REGS];
        vals = '{dur_a, dur_b, dur_c, blink_half, warn_half};
        drain_results();
        for (int r = 0; r < NUM_REGS; r++) begin
            cfg_we   <= 1'b1;
            cfg_addr <= CFG_ADDR_WIDTH'(r);
            cfg_data <= vals[r];
            @(posedge aclk);
            reg_val[r] = vals[r];
        end
        cfg_addr <= REG_UNUSED;
        cfg_data <= CFG_WIDTH'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_WIDTH-1:0] rand_duration();
        case ($urandom_range(0, 11))
            0:       return '1;
            1:       return CFG_WIDTH'(1);
            2:       return '0;
            default: return CFG_WIDTH'($urandom_range(2, 40));
        endcase
    endfunction

    function automatic logic [CFG_WIDTH-1:0] rand_half();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            default: return CFG_WIDTH'($urandom_range(1, 6));
        endcase
    endfunction

    // reset settings: link light, triggers in every group, no-op code, clear
    task automatic test_reset_settings();
        push_item(CMD_TICK, 3'd0, 1'b1);
        push_item(CMD_TICK, 3'd0, 1'b0);
        push_item(CMD_TRIGGER, 3'd0, 1'b0);
        push_item(CMD_TRIGGER, 3'd7, 1'b1);
        push_item(CMD_TRIGGER, 3'd3, 1'b0);
        push_item(CMD_TICK, 3'd5, 1'b1);
        push_item(CMD_UNUSED, 3'd5, 1'b1);
        push_item(CMD_CLEAR, 3'd2, 1'b0);
        push_item(CMD_TICK, 3'd0, 1'b0);
    endtask

    // zero and full-scale durations and half periods
    task automatic test_extreme_settings();
        // zero duration ends on the first tick
        configure('0, '0, '0, '0, '0);
        push_item(CMD_TRIGGER, 3'd1, 1'b0);
        push_item(CMD_TRIGGER, 3'd4, 1'b0);
        push_item(CMD_TICK, 3'd0, 1'b1);
        // zero half period toggles on every tick
        configure('1, '1, '1, '0, '0);
        push_item(CMD_TRIGGER, 3'd2, 1'b0);
        push_item(CMD_TRIGGER, 3'd6, 1'b0);
        push_item(CMD_TICK, 3'd0, 1'b1);
        push_item(CMD_TICK, 3'd0, 1'b0);
        push_item(CMD_TICK, 3'd0, 1'b1);
        // shortest nonzero duration, longest half periods
        configure(CFG_WIDTH'(1), CFG_WIDTH'(1), CFG_WIDTH'(1), '1, '1);
        push_item(CMD_TRIGGER, 3'd5, 1'b1);
        push_item(CMD_TRIGGER, 3'd0, 1'b1);
        push_item(CMD_TICK, 3'd0, 1'b0);
        push_item(CMD_TRIGGER, 3'd6, 1'b0);
        push_item(CMD_TICK, 3'd0, 1'b1);
    endtask

    // mostly ticks and triggers under random, mostly short settings
    task automatic test_random_phases();
        int                    pick;
        logic [CMD_WIDTH-1:0]  cmd;
        for (int phase = 0; phase < 8; phase++) begin
            configure(rand_duration(), rand_duration(), rand_duration(),
                      rand_half(), rand_half());
            steady = (phase == 2 || phase == 5);
            for (int n = 0; n < 82; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 62)      cmd = CMD_TICK;
                else if (pick < 90) cmd = CMD_TRIGGER;
                else if (pick < 96) cmd = CMD_CLEAR;
                else                cmd = CMD_UNUSED;
                // hold off once until the block has caught up
                if (phase == 4 && n == 40) drain_results();
                push_item(cmd, CHAN_WIDTH'($urandom), 1'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    // result acceptance with random stalls (none while steady)
    initial begin : result_sink
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin
        lights_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_lights.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result %h with nothing expected", $realtime, m_tdata);
                mismatches++;
            end else begin
                want = expected_lights.pop_front();
                if (m_tdata[7:0] !== want.lamps || m_tdata[15:8] !== want.active ||
                    m_tdata[16] !== want.warn || m_tdata[17] !== want.link ||
                    m_tdata[M_TDATA_WIDTH-1:M_FIELDS_WIDTH] !== '0) begin
                    // each pair is expected/actual
                    if (mismatches < 10)
                        $display("%0t: lamps %h/%h act %h/%h warn %b/%b link %b/%b pad %h",
                                 $realtime,
                                 want.lamps, m_tdata[7:0], want.active, m_tdata[15:8],
                                 want.warn, m_tdata[16], want.link, m_tdata[17],
                                 m_tdata[M_TDATA_WIDTH-1:M_FIELDS_WIDTH]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn  <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_addr <= REG_GROUP_A_DURATION;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_TICK;
        // mirror starts from the reset state
        chan_on    = '0;
        chan_lit   = '0;
        warn_on    = 1'b0;
        warn_lit   = 1'b0;
        warn_count = '0;
        link_lit   = 1'b0;
        for (int i = 0; i < NUM_CHAN; i++) begin
            since_start[i]  = '0;
            since_toggle[i] = '0;
        end
        reg_val[REG_GROUP_A_DURATION] = GROUP_A_DURATION_RST;
        reg_val[REG_GROUP_B_DURATION] = GROUP_B_DURATION_RST;
        reg_val[REG_GROUP_C_DURATION] = GROUP_C_DURATION_RST;
        reg_val[REG_BLINK_HALF]       = BLINK_HALF_RST;
        reg_val[REG_WARN_HALF]        = WARN_HALF_RST;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_settings();
        test_extreme_settings();
        test_random_phases();

        drain_results();
        repeat (5) @(posedge aclk);
        if (mismatches == 0 && expected_lights.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
